// File: rtl/core/wsrm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard star matcher package
// Shared word types, byte constants, mode codes and cell interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wsrm_pkg;

    // Default number of pattern tokens the cell row can hold.
    localparam int MAX_TOKENS_DEF = 32;

    // Special pattern bytes.
    localparam logic [7:0] DOT_BYTE  = 8'h2E;
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    // Item mode codes; the fourth code is ignored.
    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_TEXT    = 2'd1;
    localparam logic [1:0] MODE_FINISH  = 2'd2;

    // Input word: one pattern byte, one text byte or a finish request.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } item_word_t;

    // Result word, sent once per finish request.
    typedef struct packed {
        logic matched;
        logic pattern_invalid;
    } result_word_t;

    // Command from the controller to one cell.
    typedef struct packed {
        logic       clear;
        logic       advance;
        logic       text_started;
        logic       write;
        logic       set_star;
        logic [7:0] symbol;
    } cell_cmd_t;

    // Signals handed from one cell to the next position up.
    typedef struct packed {
        logic hop;
        logic seed;
        logic close;
    } link_t;

    // Status a cell reports back to the controller.
    typedef struct packed {
        logic used;
        logic star;
        logic cur;
    } cell_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/wsrm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard star matcher cell
// Holds one pattern token and the active bit of its position, and computes
// the next activity of its position from the link of the cell below.
// ----------------------------------------------------------------------------
`default_nettype none

module wsrm_cell
    import wsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_cmd_t  cmd,
    input  wire link_t      link_in,
    output link_t           link_out,
    output cell_stat_t      stat
);

    // Token payload, no reset needed.
    logic [7:0] sym_reg;
    logic       wild_reg;
    logic       star_reg;

    // Control state.
    logic       used_reg;
    logic       act_reg;
    logic       used_next;
    logic       act_next;

    logic       seed;
    logic       cur;
    logic       hit;
    logic       nxt;
    logic       closed;

    // Activity of this position: the stored bit once text runs, otherwise
    // the closure of the start position alone.
    always_comb
    begin
        seed   = link_in.seed;
        cur    = cmd.text_started ? act_reg : seed;
        hit    = used_reg && cur && (wild_reg || (sym_reg == cmd.symbol));
        nxt    = link_in.hop || (hit && star_reg);
        closed = nxt || link_in.close;
    end

    // Links toward the next position up.
    always_comb
    begin
        link_out.hop   = hit && !star_reg;
        link_out.seed  = seed && star_reg && used_reg;
        link_out.close = closed && star_reg && used_reg;
    end

    always_comb
    begin
        stat.used = used_reg;
        stat.star = star_reg;
        stat.cur  = cur;
    end

    // Next control state.
    always_comb
    begin
        used_next = used_reg;
        act_next  = act_reg;
        if (cmd.clear)
        begin
            used_next = 1'b0;
            act_next  = 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                used_next = 1'b1;
            end
            if (cmd.advance)
            begin
                act_next = closed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            act_reg  <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            act_reg  <= act_next;
        end
    end

    // Token payload.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            sym_reg  <= cmd.symbol;
            wild_reg <= (cmd.symbol == DOT_BYTE);
            star_reg <= 1'b0;
        end
        else if (cmd.set_star)
        begin
            star_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wildcard_star_regex_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard star regex matcher
// Whole-string matcher for patterns with '.' and '*', built as a row of
// token cells that step an active-position vector one text byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_ready, item) carries one word per
//   pattern byte, text byte or finish request. Pattern bytes come first and
//   fill the cell row; text bytes then advance the active positions.
//   A finish word yields one result word on the result channel and clears
//   the block for the next pattern; pattern and text words yield nothing.
//   Throughput is one word per cycle while no result waits. A finish
//   result is registered and shows on the result channel in the cycle
//   after the finish word is taken. The star closure of each text word
//   ripples combinationally through the whole cell row, so the row length
//   sets the clock period.
//   When a result waits and result_ready is low, item_ready drops until the
//   result is taken.
//   Reset empties the token row and clears all activity and flags; the
//   block is ready to take words as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_star_regex_matcher
    import wsrm_pkg::*;
#(
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_ready,
    input  wire item_word_t   item,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_word_t      result
);

    // Cell row wiring.
    cell_cmd_t  cmd  [MAX_TOKENS];
    cell_stat_t stat [MAX_TOKENS];
    link_t      link [MAX_TOKENS+1];

    logic [MAX_TOKENS-1:0] used_vec;
    logic [MAX_TOKENS-1:0] star_vec;
    logic [MAX_TOKENS-1:0] cur_vec;
    logic [MAX_TOKENS-1:0] first_free;
    logic [MAX_TOKENS-1:0] last_used;

    // Control state.
    logic          text_started_reg;
    logic          text_started_next;
    logic          bad_reg;
    logic          bad_next;
    logic          final_reg;
    logic          final_next;
    logic          result_valid_reg;
    logic          result_valid_next;
    result_word_t  result_reg;

    logic          accept;
    logic          is_star;
    logic          take_pattern;
    logic          star_bad;
    logic          star_set;
    logic          push;
    logic          overflow;
    logic          advance;
    logic          finish;
    logic          empty;
    logic          full;
    logic          last_star;
    logic          cur_final;
    logic          hit;

    // Handshake.
    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Row occupancy: tokens fill the cells from the bottom without gaps.
    assign empty      = !used_vec[0];
    assign full       = used_vec[MAX_TOKENS-1];
    assign first_free = ~used_vec & {used_vec[MAX_TOKENS-2:0], 1'b1};
    assign last_used  = used_vec & ~{1'b0, used_vec[MAX_TOKENS-1:1]};
    assign last_star  = |(last_used & star_vec);

    // Decode of the accepted word.
    always_comb
    begin
        is_star      = (item.symbol == STAR_BYTE);
        take_pattern = accept && (item.mode == MODE_PATTERN) && !text_started_reg;
        star_bad     = take_pattern && is_star && (empty || last_star);
        star_set     = take_pattern && is_star && !empty && !last_star;
        push         = take_pattern && !is_star && !full;
        overflow     = take_pattern && !is_star && full;
        advance      = accept && (item.mode == MODE_TEXT);
        finish       = accept && (item.mode == MODE_FINISH);
    end

    // Start of the chain: the start position always seeds the closure.
    assign link[0] = '{hop: 1'b0, seed: 1'b1, close: 1'b0};

    // Cell row.
    for (genvar k = 0; k < MAX_TOKENS; k++)
    begin : g_cell
        always_comb
        begin
            cmd[k].clear        = finish;
            cmd[k].advance      = advance;
            cmd[k].text_started = text_started_reg;
            cmd[k].write        = push && first_free[k];
            cmd[k].set_star     = star_set && last_used[k];
            cmd[k].symbol       = item.symbol;
        end

        wsrm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd[k]),
            .link_in  (link[k]),
            .link_out (link[k+1]),
            .stat     (stat[k])
        );

        assign used_vec[k] = stat[k].used;
        assign star_vec[k] = stat[k].star;
        assign cur_vec[k]  = stat[k].cur;
    end

    // End position past the last cell, and the position at the token count.
    assign cur_final = text_started_reg ? final_reg : link[MAX_TOKENS].seed;
    assign hit       = (|(cur_vec & first_free)) || (cur_final && full);

    // Next control state.
    always_comb
    begin
        text_started_next = text_started_reg;
        bad_next          = bad_reg;
        final_next        = final_reg;
        result_valid_next = result_valid_reg && !result_ready;
        if (finish)
        begin
            text_started_next = 1'b0;
            bad_next          = 1'b0;
            final_next        = 1'b0;
            result_valid_next = 1'b1;
        end
        else
        begin
            if (advance)
            begin
                text_started_next = 1'b1;
                final_next        = link[MAX_TOKENS].hop || link[MAX_TOKENS].close;
            end
            if (star_bad || overflow)
            begin
                bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_started_reg <= 1'b0;
            bad_reg          <= 1'b0;
            final_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            text_started_reg <= text_started_next;
            bad_reg          <= bad_next;
            final_reg        <= final_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg.matched         <= hit && !bad_reg;
            result_reg.pattern_invalid <= bad_reg;
        end
    end

`ifndef SYNTHESIS
    // A taken finish word always leaves a result waiting.
    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> result_valid)
        else $error("finish word did not produce a result");

    // An invalid pattern never reports a match.
    a_invalid_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.matched && result.pattern_invalid))
        else $error("match reported for an invalid pattern");

    // Tokens occupy a gap-free run of cells from the bottom.
    a_used_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (used_vec & (used_vec + {{(MAX_TOKENS-1){1'b0}}, 1'b1})) == '0)
        else $error("token cells are not contiguous");

    // Finish empties the row and drops back to pattern loading.
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (used_vec == '0) && !text_started_reg && !bad_reg)
        else $error("finish did not clear the matcher");
`endif

endmodule

`default_nettype wire
